// ----- rtl/core/assert_macros.svh -----
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define OWBM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define OWBM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/owbm_pkg.sv -----
package owbm_pkg;

   localparam int TICK_COUNT_WIDTH_DEF = 12;
   localparam int REG_W                = 12;
   localparam int NUM_REGS             = 7;
   localparam int CSR_INDEX_W          = 3;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_RESET = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RESET_LOW       = 3'd0,
      REG_PRESENCE_SAMPLE = 3'd1,
      REG_RESET_TAIL      = 3'd2,
      REG_WRITE_ONE_LOW   = 3'd3,
      REG_WRITE_SLOT      = 3'd4,
      REG_READ_SAMPLE     = 3'd5,
      REG_READ_TAIL       = 3'd6
   } reg_index_type;

   localparam logic [NUM_REGS-1:0][REG_W-1:0] REG_DEFAULTS = {
      12'd105,   // read_tail_ticks
      12'd15,    // read_sample_ticks
      12'd105,   // write_slot_ticks
      12'd1,     // write_one_low_ticks
      12'd430,   // reset_tail_ticks
      12'd65,    // presence_sample_ticks
      12'd500    // reset_low_ticks
   };

   typedef enum logic [7:0] {
      PH_IDLE      = 8'b0000_0001,
      PH_RST_LOW   = 8'b0000_0010,
      PH_RST_WAIT  = 8'b0000_0100,
      PH_RST_TAIL  = 8'b0000_1000,
      PH_WR_SLOT   = 8'b0001_0000,
      PH_WR_REC    = 8'b0010_0000,
      PH_RD_SAMPLE = 8'b0100_0000,
      PH_RD_TAIL   = 8'b1000_0000
   } phase_type;

endpackage

// ----- rtl/core/owbm_csr.sv -----
module owbm_csr
   import owbm_pkg::*;
#(
   parameter int TC_W = TICK_COUNT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]             csr_index,
   input  logic [REG_W-1:0]                   csr_write_data,
   output logic [NUM_REGS-1:0][TC_W-1:0]      lim
);

   localparam int CmpW = (TC_W > REG_W) ? TC_W : REG_W;
   localparam logic [CmpW-1:0] CntMax = CmpW'((1 << TC_W) - 1);

   logic [NUM_REGS-1:0][REG_W-1:0] regs_ff;
   logic [NUM_REGS-1:0][REG_W-1:0] regs_in;
   logic [NUM_REGS-1:0][CmpW-1:0]  reg_wide;

   always_comb begin
      regs_in = regs_ff;
      if (csr_write_enable && (csr_index < CSR_INDEX_W'(NUM_REGS))) begin
         regs_in[csr_index] = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= REG_DEFAULTS;
      end else begin
         regs_ff <= regs_in;
      end
   end

   // clip to the largest count the tick counter holds
   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         reg_wide[i] = CmpW'(regs_ff[i]);
         lim[i]      = (reg_wide[i] > CntMax) ? TC_W'(CntMax) : TC_W'(reg_wide[i]);
      end
   end

endmodule

// ----- rtl/core/one_wire_bus_master.sv -----
// Single-wire bus master, driven by one transaction per microsecond tick.
// Request channel (req_valid/req_stall): action, write_data and the sampled
// line_level. While idle, action reset, write or read starts an operation;
// any other transaction counts as one tick of the running operation.
// Response channel (rsp_valid/rsp_stall): one transaction per request with
// the line drive for that tick, op_done, no_presence, read_data, busy_res
// and start_refused.
// Pipeline: a taken request loads the input register, and its response loads
// the response register when the input register advances. Throughput: one
// transaction per cycle while the receiver does not stall; the whole tick
// update is one pass of logic between the two registers.
// When the receiver stalls, the response holds and the input register
// takes at most one more request, then req_stall rises until the response
// drains.
// Reset (synchronous, active high) returns the bus state to idle, clears
// presence and read data, restores register defaults and empties both
// registers. Configuration writes (csr_*) take effect the next cycle; the user
// must make them only while no transaction is in flight; the block does not enforce it.
module one_wire_bus_master
   import owbm_pkg::*;
#(
   parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic [7:0]             req_write_data,
   input  logic                   req_line_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_line_drive_low,
   output logic                   rsp_op_done,
   output logic                   rsp_no_presence,
   output logic [7:0]             rsp_read_data,
   output logic                   rsp_busy_res,
   output logic                   rsp_start_refused,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_write_data
);

   localparam int TC_W = TICK_COUNT_WIDTH;
   localparam logic [TC_W-1:0] TickMax = {TC_W{1'b1}};

   logic [NUM_REGS-1:0][TC_W-1:0] lim;

   logic            in_valid_ff, in_valid_in;
   action_type      in_action_ff;
   logic [7:0]      in_write_data_ff;
   logic            in_line_level_ff;

   phase_type       phase_ff, phase_in;
   logic [TC_W-1:0] tick_ff, tick_in, tick_bump, low_len;
   logic [2:0]      bit_ff, bit_in;
   logic [7:0]      shift_ff, shift_in;
   logic            presence_ff, presence_in;
   logic [7:0]      last_read_ff, last_read_in;
   logic            done, refused, drive;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_drive_ff, rsp_done_ff, rsp_presence_ff, rsp_busy_ff, rsp_refused_ff;
   logic [7:0]      rsp_read_data_ff;

   logic            advance, take;

   owbm_csr #(
      .TC_W (TC_W)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .lim              (lim)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign tick_bump = (tick_ff == TickMax) ? tick_ff : tick_ff + TC_W'(1);

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      presence_in  = presence_ff;
      last_read_in = last_read_ff;
      done         = 1'b0;
      refused      = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (in_action_ff != ACT_TICK) begin
            tick_in = '0;
            bit_in  = '0;
            unique case (in_action_ff)
               ACT_RESET: begin
                  phase_in = PH_RST_LOW;
               end
               ACT_WRITE: begin
                  shift_in = in_write_data_ff;
                  phase_in = PH_WR_SLOT;
               end
               default: begin
                  shift_in = '0;
                  phase_in = PH_RD_SAMPLE;
               end
            endcase
         end
      end else begin
         refused = (in_action_ff != ACT_TICK);
         tick_in = tick_bump;
         unique case (phase_ff)
            PH_RST_LOW: begin
               if (tick_bump >= lim[REG_RESET_LOW]) begin
                  phase_in = PH_RST_WAIT;
                  tick_in  = '0;
               end
            end
            PH_RST_WAIT: begin
               if (tick_bump >= lim[REG_PRESENCE_SAMPLE]) begin
                  presence_in = in_line_level_ff;
                  phase_in    = PH_RST_TAIL;
                  tick_in     = '0;
               end
            end
            PH_RST_TAIL: begin
               if (tick_bump >= lim[REG_RESET_TAIL]) begin
                  phase_in = PH_IDLE;
                  tick_in  = '0;
                  done     = 1'b1;
               end
            end
            PH_WR_SLOT: begin
               if (tick_bump >= lim[REG_WRITE_SLOT]) begin
                  tick_in = '0;
                  if (bit_ff == 3'd7) begin
                     phase_in = PH_IDLE;
                     bit_in   = '0;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_WR_REC;
                  end
               end
            end
            PH_WR_REC: begin
               bit_in   = bit_ff + 3'd1;
               shift_in = {1'b0, shift_ff[7:1]};
               phase_in = PH_WR_SLOT;
               tick_in  = '0;
            end
            PH_RD_SAMPLE: begin
               if (tick_bump >= lim[REG_READ_SAMPLE]) begin
                  shift_in = {in_line_level_ff, shift_ff[7:1]};
                  phase_in = PH_RD_TAIL;
                  tick_in  = '0;
               end
            end
            PH_RD_TAIL: begin
               if (tick_bump >= lim[REG_READ_TAIL]) begin
                  tick_in = '0;
                  if (bit_ff == 3'd7) begin
                     last_read_in = shift_ff;
                     phase_in     = PH_IDLE;
                     bit_in       = '0;
                     done         = 1'b1;
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = PH_RD_SAMPLE;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      low_len = shift_in[0] ? lim[REG_WRITE_ONE_LOW] : lim[REG_WRITE_SLOT];
      if (low_len == '0) begin
         low_len = TC_W'(1);
      end
      priority if (phase_in == PH_RST_LOW) begin
         drive = 1'b1;
      end else if (phase_in == PH_WR_SLOT) begin
         drive = (tick_in < low_len);
      end else if (phase_in == PH_RD_SAMPLE) begin
         drive = (tick_in == '0);
      end else begin
         drive = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         presence_ff  <= 1'b0;
         last_read_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            bit_ff       <= bit_in;
            shift_ff     <= shift_in;
            presence_ff  <= presence_in;
            last_read_ff <= last_read_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_action_ff     <= action_type'(req_action);
         in_write_data_ff <= req_write_data;
         in_line_level_ff <= req_line_level;
      end
      if (advance) begin
         rsp_drive_ff     <= drive;
         rsp_done_ff      <= done;
         rsp_presence_ff  <= presence_in;
         rsp_read_data_ff <= last_read_in;
         rsp_busy_ff      <= (phase_in != PH_IDLE);
         rsp_refused_ff   <= refused;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_drive_low = rsp_drive_ff;
   assign rsp_op_done        = rsp_done_ff;
   assign rsp_no_presence    = rsp_presence_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_busy_res       = rsp_busy_ff;
   assign rsp_start_refused  = rsp_refused_ff;

endmodule

// ----- rtl/core/owbm_checker.sv -----
`include "assert_macros.svh"

module owbm_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_line_drive_low,
   input logic rsp_op_done,
   input logic rsp_busy_res,
   input logic rsp_start_refused
);

   logic busy_or_done;

   assign busy_or_done = rsp_busy_res || rsp_op_done;

   `OWBM_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "response valid after reset")
   `OWBM_ASSERT(a_done_idle, (rsp_valid && rsp_op_done) |-> !rsp_busy_res, "done while busy")
   `OWBM_ASSERT(a_drive_busy, (rsp_valid && rsp_line_drive_low) |-> rsp_busy_res, "idle drive")
   `OWBM_ASSERT(a_refuse_busy, (rsp_valid && rsp_start_refused) |-> busy_or_done, "idle refuse")
   `OWBM_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> rsp_valid, "stalled response dropped")

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (.*);
